[rtl/core/huffman_symbol_encoder_defines.svh]
// Assertion macros used by the encoder top-level RTL.
`ifndef HUFFMAN_SYMBOL_ENCODER_DEFINES_SVH
`define HUFFMAN_SYMBOL_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define HSE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset
`define HSE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/hse_pkg.sv]
`timescale 1ns / 1ps

package hse_pkg;

	// Default sizing
	localparam int MAX_SYMBOLS_DEF = 256;
	localparam int MAX_CODE_BITS   = 32;
	localparam int MAX_RUN         = 64;
	localparam int LEN_CAP         = (MAX_CODE_BITS < 63) ? MAX_CODE_BITS : 63;

	// Field widths
	localparam int VALUE_W    = 16;
	localparam int CODE_W     = 32;
	localparam int LEN_W      = 6;
	localparam int PREV_W     = 8;
	localparam int SIZE_CFG_W = 9;

	// Queue depths
	localparam int CMD_DEPTH = 4;
	localparam int RES_DEPTH = 2;

	// Register map: index is paddr[2]
	localparam logic REG_SIZE = 1'b0;
	localparam logic [SIZE_CFG_W-1:0] CFG_SIZE_RST = 9'd256;

	typedef enum logic [2:0] {
		OP_LOAD    = 3'd0,
		OP_PLAIN   = 3'd1,
		OP_DIFF    = 3'd2,
		OP_ESC     = 3'd3,
		OP_SETPREV = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_RUN   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CMD_LOAD,
		CMD_PLAIN,
		CMD_DIFF,
		CMD_ESC,
		CMD_SETPREV,
		CMD_ERR
	} cmd_kind_t;

	// Classified request handed from front to back
	typedef struct packed {
		cmd_kind_t           kind;
		status_t             status;
		logic [CODE_W-1:0]   code;
		logic [LEN_W-1:0]    len;
		logic [VALUE_W-1:0]  value;
	} cmd_t;

	// Codebook entry
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} ent_t;

	// One result
	typedef struct packed {
		logic [CODE_W-1:0] code_bits;
		logic [LEN_W-1:0]  code_length;
		logic              last;
		status_t           status;
	} res_t;

	// Back-end sequencer states
	typedef enum logic [2:0] {
		B_IDLE,
		B_MOD,
		B_DIFF,
		B_ESC,
		B_READ,
		B_EMIT
	} bst_t;

endpackage

[rtl/core/huffman_symbol_encoder.sv]
`timescale 1ns / 1ps
// Huffman symbol encoder with a loadable codebook.
// Requests enter on a queue-style port: a request is taken when push is high
// and full is low. Results leave the same way: the oldest result is on the
// result ports while empty is low and is taken when pop is high.
// codebook_size is written over the APB port (register 0, byte address 0).
// A front stage classifies each request (range checks, running length) and
// puts it into a 4-entry command queue; a back sequencer carries it out
// against the codebook memory and fills a 2-entry result queue.
// Plain encode reads the codebook, then emits; a range error is emitted
// directly; difference encode first forms the symbol from the previous
// index, which a restoring loop reduces beforehand by the codebook size when
// it is not below it. Loads and set-previous finish as the back end takes
// them. Escape steps, reads memory and emits for each of runs+1 results.
// Throughput is set by the back sequencer and its single memory read port.
// Reset empties both queues, clears the running length and previous index
// and sets codebook_size to 256; the codebook itself is not cleared.
// When pop is held low the result queue fills, the back end waits, and full
// rises once the command queue is full.

module huffman_symbol_encoder #(
	parameter int MAX_SYMBOLS = hse_pkg::MAX_SYMBOLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        push,
	output logic        full,
	input  logic [2:0]  opcode,
	input  logic        first_entry,
	input  logic [7:0]  symbol_slot,
	input  logic [31:0] code_bits_in,
	input  logic [5:0]  length_increment,
	input  logic [15:0] value,
	// result channel
	input  logic        pop,
	output logic        empty,
	output logic [31:0] code_bits,
	output logic [5:0]  code_length,
	output logic        last,
	output logic [1:0]  status,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import hse_pkg::*;

	localparam int SW = $clog2(MAX_SYMBOLS + 1);

	logic [SIZE_CFG_W-1:0] size_q;
	logic [SW-1:0]         size, top;
	logic                  accept, enq, cmd_full, cmd_empty, cmd_pop;
	logic                  res_full, res_push;
	cmd_t                  cmd_in, cmd_out;
	res_t                  res_in, res_out;

	// Configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SIZE) ? 32'(size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= CFG_SIZE_RST;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_SIZE) begin
			size_q <= pwdata[SIZE_CFG_W-1:0];
		end
	end

	// Effective size limited to 2..MAX_SYMBOLS
	always_comb begin
		if (size_q < SIZE_CFG_W'(2))
			size = SW'(2);
		else if (32'(size_q) > 32'(MAX_SYMBOLS))
			size = SW'(MAX_SYMBOLS);
		else
			size = SW'(size_q);
		top = size - 1'b1;
	end

	assign full   = cmd_full;
	assign accept = push && !cmd_full;

	hse_front #(
		.MAX_SYMBOLS(MAX_SYMBOLS),
		.SW(SW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.opcode(opcode),
		.first_entry(first_entry),
		.symbol_slot(symbol_slot),
		.code_bits_in(code_bits_in),
		.length_increment(length_increment),
		.value(value),
		.size(size),
		.top(top),
		.enq(enq),
		.cmd(cmd_in)
	);

	hse_fifo #(
		.DW($bits(cmd_t)),
		.DEPTH(CMD_DEPTH)
	) u_cmd_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(enq),
		.wdata(cmd_in),
		.full(cmd_full),
		.pop(cmd_pop),
		.rdata(cmd_out),
		.empty(cmd_empty)
	);

	hse_back #(
		.MAX_SYMBOLS(MAX_SYMBOLS),
		.SW(SW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.size(size),
		.top(top),
		.cmd(cmd_out),
		.cmd_empty(cmd_empty),
		.cmd_pop(cmd_pop),
		.res(res_in),
		.res_full(res_full),
		.res_push(res_push)
	);

	hse_fifo #(
		.DW($bits(res_t)),
		.DEPTH(RES_DEPTH)
	) u_res_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.wdata(res_in),
		.full(res_full),
		.pop(pop),
		.rdata(res_out),
		.empty(empty)
	);

	assign code_bits   = res_out.code_bits;
	assign code_length = res_out.code_length;
	assign last        = res_out.last;
	assign status      = res_out.status;

	// Checks
	`include "huffman_symbol_encoder_defines.svh"

	`HSE_ASSERT_IMP(a_err_shape, clk, arst_n, !empty && status != ST_OK, last && code_length == '0 && code_bits == '0, "error result must be a lone empty final result")
	`HSE_ASSERT_IMP(a_status_code, clk, arst_n, !empty, status == ST_OK || status == ST_RANGE || status == ST_RUN, "unknown status code on result")
	`HSE_ASSERT_NXT(a_full_needs_push, clk, arst_n, !push && !full, !full, "command queue filled without a request")

endmodule

[rtl/core/hse_fifo.sv]
`timescale 1ns / 1ps

module hse_fifo #(
	parameter int DW    = 8,
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] wdata,
	output logic          full,
	input  logic          pop,
	output logic [DW-1:0] rdata,
	output logic          empty
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [DW-1:0] store_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = store_q[rptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push)
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (do_pop)
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// Payload slots
	always_ff @(posedge clk) begin
		if (do_push)
			store_q[wptr_q] <= wdata;
	end

endmodule

[rtl/core/hse_front.sv]
`timescale 1ns / 1ps

module hse_front #(
	parameter int MAX_SYMBOLS = hse_pkg::MAX_SYMBOLS_DEF,
	parameter int SW          = $clog2(MAX_SYMBOLS + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [2:0]                   opcode,
	input  logic                         first_entry,
	input  logic [7:0]                   symbol_slot,
	input  logic [hse_pkg::CODE_W-1:0]   code_bits_in,
	input  logic [hse_pkg::LEN_W-1:0]    length_increment,
	input  logic [hse_pkg::VALUE_W-1:0]  value,
	input  logic [SW-1:0]                size,
	input  logic [SW-1:0]                top,
	output logic                         enq,
	output hse_pkg::cmd_t                cmd
);
	import hse_pkg::*;

	localparam int RUN_W = $clog2(MAX_RUN + 1);
	localparam int LIM_W = SW + RUN_W;

	logic [LEN_W-1:0] rl_q;
	logic [LEN_W:0]   sum;
	logic [LEN_W-1:0] len_new;
	logic [LIM_W-1:0] lim;
	logic             in_range, slot_ok, run_ok;

	// Running codeword length, saturating
	assign sum     = (first_entry ? '0 : {1'b0, rl_q}) + {1'b0, length_increment};
	assign len_new = (sum > (LEN_W + 1)'(LEN_CAP)) ? LEN_W'(LEN_CAP) : sum[LEN_W-1:0];

	// Range checks; an escape needs value / top < MAX_RUN
	assign lim      = LIM_W'(top) * LIM_W'(MAX_RUN);
	assign in_range = 32'(value) < 32'(size);
	assign slot_ok  = 32'(symbol_slot) < 32'(MAX_SYMBOLS);
	assign run_ok   = 32'(value) < 32'(lim);

	// Classify the request
	always_comb begin
		enq        = 1'b0;
		cmd.kind   = CMD_ERR;
		cmd.status = ST_OK;
		cmd.code   = code_bits_in;
		cmd.len    = len_new;
		cmd.value  = value;
		case (opcode_t'(opcode))
			OP_LOAD: begin
				enq       = accept && slot_ok;
				cmd.kind  = CMD_LOAD;
				cmd.value = VALUE_W'(symbol_slot);
			end
			OP_PLAIN: begin
				enq        = accept;
				cmd.kind   = in_range ? CMD_PLAIN : CMD_ERR;
				cmd.status = in_range ? ST_OK : ST_RANGE;
			end
			OP_DIFF: begin
				enq        = accept;
				cmd.kind   = in_range ? CMD_DIFF : CMD_ERR;
				cmd.status = in_range ? ST_OK : ST_RANGE;
			end
			OP_ESC: begin
				enq        = accept;
				cmd.kind   = run_ok ? CMD_ESC : CMD_ERR;
				cmd.status = run_ok ? ST_OK : ST_RUN;
			end
			OP_SETPREV: begin
				enq      = accept;
				cmd.kind = CMD_SETPREV;
			end
			default: begin
				enq = 1'b0;
			end
		endcase
	end

	// Running length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rl_q <= '0;
		end else if (accept && opcode_t'(opcode) == OP_LOAD) begin
			rl_q <= len_new;
		end
	end

endmodule

[rtl/core/hse_back.sv]
`timescale 1ns / 1ps

module hse_back #(
	parameter int MAX_SYMBOLS = hse_pkg::MAX_SYMBOLS_DEF,
	parameter int SW          = $clog2(MAX_SYMBOLS + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [SW-1:0]  size,
	input  logic [SW-1:0]  top,
	input  hse_pkg::cmd_t  cmd,
	input  logic           cmd_empty,
	output logic           cmd_pop,
	output hse_pkg::res_t  res,
	input  logic           res_full,
	output logic           res_push
);
	import hse_pkg::*;

	localparam int SYM_W = $clog2(MAX_SYMBOLS);
	localparam int CNT_W = $clog2(PREV_W);

	bst_t              state_q, state_d;
	cmd_t              cur_q;
	logic [PREV_W-1:0] prev_q, pshift_q;
	logic [SW-1:0]     r_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [VALUE_W-1:0] rem_q;
	logic [SYM_W-1:0]  sym_q;
	logic              last_q, err_q;
	ent_t              rd_q;
	ent_t              mem [MAX_SYMBOLS];

	logic              prev_lt;
	logic [SW:0]       rsh, dsum;
	logic              mem_we, mem_re, last_step, esc_more;

	assign prev_lt   = 32'(prev_q) < 32'(size);
	assign rsh       = {r_q, pshift_q[PREV_W-1]};
	assign dsum      = (SW + 1)'(cur_q.value) + {1'b0, size} - {1'b0, r_q};
	assign last_step = (cnt_q == CNT_W'(PREV_W - 1));
	assign esc_more  = 32'(rem_q) >= 32'(top);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!cmd_empty) begin
					case (cmd.kind)
						CMD_PLAIN: state_d = B_READ;
						CMD_DIFF:  state_d = prev_lt ? B_DIFF : B_MOD;
						CMD_ESC:   state_d = B_ESC;
						CMD_ERR:   state_d = B_EMIT;
						default:   state_d = B_IDLE;
					endcase
				end
			end
			B_MOD:  state_d = last_step ? B_DIFF : B_MOD;
			B_DIFF: state_d = B_READ;
			B_ESC:  state_d = B_READ;
			B_READ: state_d = B_EMIT;
			B_EMIT: begin
				if (!res_full)
					state_d = last_q ? B_IDLE : B_ESC;
			end
			default: state_d = B_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd_pop  = (state_q == B_IDLE) && !cmd_empty;
		mem_we   = cmd_pop && cmd.kind == CMD_LOAD;
		mem_re   = (state_q == B_READ);
		res_push = (state_q == B_EMIT) && !res_full;
		if (err_q) begin
			res.code_bits   = '0;
			res.code_length = '0;
			res.last        = 1'b1;
			res.status      = cur_q.status;
		end else begin
			res.code_bits   = rd_q.code;
			res.code_length = rd_q.len;
			res.last        = last_q;
			res.status      = ST_OK;
		end
	end

	// State and previous index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			prev_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd_pop && cmd.kind == CMD_SETPREV)
				prev_q <= cmd.value[PREV_W-1:0];
			else if (state_q == B_DIFF)
				prev_q <= cur_q.value[PREV_W-1:0];
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (cmd_pop) begin
					cur_q    <= cmd;
					last_q   <= 1'b1;
					err_q    <= (cmd.kind == CMD_ERR);
					rem_q    <= cmd.value;
					sym_q    <= SYM_W'(cmd.value);
					r_q      <= prev_lt ? SW'(prev_q) : '0;
					pshift_q <= prev_q;
					cnt_q    <= '0;
				end
			end
			// Restoring reduction of previous index, one bit a cycle
			B_MOD: begin
				r_q      <= (rsh >= {1'b0, size}) ? SW'(rsh - {1'b0, size}) : rsh[SW-1:0];
				pshift_q <= pshift_q << 1;
				cnt_q    <= cnt_q + 1'b1;
			end
			B_DIFF: begin
				sym_q <= (dsum >= {1'b0, size}) ? SYM_W'(dsum - {1'b0, size}) : SYM_W'(dsum);
			end
			// Take off one top symbol per result
			B_ESC: begin
				if (esc_more) begin
					sym_q  <= SYM_W'(top);
					last_q <= 1'b0;
					rem_q  <= rem_q - VALUE_W'(top);
				end else begin
					sym_q  <= SYM_W'(rem_q);
					last_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Codebook memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[SYM_W'(cmd.value)] <= '{code: cmd.code, len: cmd.len};
		if (mem_re)
			rd_q <= mem[sym_q];
	end

endmodule
